// ===== rtl/dwvp_pkg.sv =====
// Shared types, constants and waveform table builders for the dual DDS voice unit.
`default_nettype none

package dwvp_pkg;

	// Configuration port
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned TUNE_W     = 32;
	localparam int unsigned NOTE_W     = 20;
	localparam int unsigned SAMPLE_W   = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INCR_A       = 3'd0,
		CFG_INCR_B       = 3'd1,
		CFG_WAVE_A       = 3'd2,
		CFG_WAVE_B       = 3'd3,
		CFG_OUTPUT_MODE  = 3'd4,
		CFG_NOTE_SAMPLES = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_TRI    = 2'd2,
		WAVE_ZERO   = 2'd3
	} wave_t;

	// Mode three is taken as stereo
	typedef enum logic [1:0] {
		MODE_MONO     = 2'd0,
		MODE_MIX      = 2'd1,
		MODE_STEREO   = 2'd2,
		MODE_STEREO_X = 2'd3
	} out_mode_t;

	// DAC command framing
	localparam logic [15:0] CHAN_A_BITS = 16'h3000;
	localparam logic [15:0] CHAN_B_BITS = 16'hB000;
	localparam logic [11:0] MIDSCALE    = 12'd2048;
	localparam logic signed [SAMPLE_W-1:0] PEAK = 12'sd2047;

	// Sine builder: Taylor series in unsigned Q55
	localparam int unsigned SINE_FRAC  = 55;
	localparam int unsigned SINE_TERMS = 64;
	localparam longint unsigned TWO_PI_MILLI = 64'd6283;
	localparam longint signed TRI_SPAN = 64'sd4094;

	typedef struct packed {
		logic start_note;
	} tick_t;

	typedef struct packed {
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic        b_valid;
		logic        note_done;
	} sample_t;

	// Unsigned 64-bit quotient by restoring long division, elaboration only
	function automatic longint unsigned udiv64(input longint unsigned a,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], a[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sine table entry, evaluated at elaboration only
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx,
		input int unsigned size);
		longint unsigned num;
		longint unsigned den;
		longint unsigned term;
		longint unsigned q;
		longint unsigned r;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned mag;
		longint unsigned v;
		logic [SAMPLE_W-1:0] vt;
		bit negative;
		num  = 64'(idx) * TWO_PI_MILLI;
		term = 64'd1 << SINE_FRAC;
		pos  = 64'd0;
		neg  = 64'd0;
		for (int unsigned k = 1; k <= SINE_TERMS; k++) begin
			den  = 64'd1000 * 64'(size) * 64'(k);
			q    = udiv64(term, den);
			r    = term - q * den;
			term = q * num + udiv64(r * num, den);
			if (k[1:0] == 2'd1)
				pos = pos + term;
			else if (k[1:0] == 2'd3)
				neg = neg + term;
		end
		negative = (neg > pos);
		mag = negative ? (neg - pos) : (pos - neg);
		v = ((mag >> 20) * 64'd2047) >> (SINE_FRAC - 20);
		if (v > 64'd2047)
			v = 64'd2047;
		vt = v[SAMPLE_W-1:0];
		return negative ? -$signed(vt) : $signed(vt);
	endfunction

	// Triangle table entry, truncated toward zero, elaboration only
	function automatic logic signed [SAMPLE_W-1:0] tri_entry(input int unsigned idx,
		input int unsigned size);
		longint signed h;
		longint signed i;
		longint signed n;
		longint signed v;
		longint unsigned m;
		bit neg_n;
		h = longint'(size >> 1);
		i = longint'(idx);
		if (i < h)
			n = i * TRI_SPAN - 64'sd2047 * h;
		else
			n = 64'sd2047 * h - (i - h) * TRI_SPAN;
		neg_n = (n < 0);
		m = udiv64(unsigned'(neg_n ? -n : n), unsigned'(h));
		v = neg_n ? -longint'(m) : longint'(m);
		return v[SAMPLE_W-1:0];
	endfunction

	// Signed sample to 12-bit offset-binary DAC code (sample + 2048)
	function automatic logic [SAMPLE_W-1:0] dac_code(input logic signed [SAMPLE_W-1:0] s);
		return s ^ MIDSCALE;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dwvp_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none

interface dwvp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/dds_waveform_voice_pair_unit.sv =====
// Top level: two DDS voices, waveform tables, output mixing and note timing.
// A tick transfer's sample word is held in the output register from the next cycle.
// Throughput: one tick per cycle while sample.ready is high; the output register frees
// as it is taken, so a new tick transfers in the same cycle the previous sample leaves.
// The phase add, table read and mix sit between the phase registers and the output
// register. Reset clears config, phases, sample counter and the output valid at once.
`default_nettype none

module dds_waveform_voice_pair_unit #(
	parameter int unsigned TABLE_SIZE = 256,
	parameter int unsigned PHASE_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dwvp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dwvp_pkg::CFG_DATA_W-1:0]    cfg_data,
	dwvp_stream_if.sink                             tick,
	dwvp_stream_if.source                           sample
);

	// Table index is (phase * TABLE_SIZE) >> PHASE_BITS; plain top bits for a power of two
	localparam int unsigned IDX_BITS  = $clog2(TABLE_SIZE);
	localparam int unsigned SW        = dwvp_pkg::SAMPLE_W;
	localparam int unsigned PROD_W    = PHASE_BITS + IDX_BITS;
	localparam int unsigned HALF_SIZE = TABLE_SIZE / 2;
	localparam logic [PROD_W-1:0]   TABLE_MUL = PROD_W'(TABLE_SIZE);
	localparam logic [IDX_BITS-1:0] IDX_HALF  = IDX_BITS'(HALF_SIZE);

	// Configuration registers
	logic [dwvp_pkg::TUNE_W-1:0] incr_a_q, incr_b_q;
	dwvp_pkg::wave_t             wave_a_q, wave_b_q;
	dwvp_pkg::out_mode_t         mode_q;
	logic [dwvp_pkg::NOTE_W-1:0] note_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_a_q <= '0;
			incr_b_q <= '0;
			wave_a_q <= dwvp_pkg::WAVE_SINE;
			wave_b_q <= dwvp_pkg::WAVE_SINE;
			mode_q   <= dwvp_pkg::MODE_MONO;
			note_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dwvp_pkg::CFG_INCR_A:       incr_a_q <= cfg_data;
				dwvp_pkg::CFG_INCR_B:       incr_b_q <= cfg_data;
				dwvp_pkg::CFG_WAVE_A:       wave_a_q <= dwvp_pkg::wave_t'(cfg_data[1:0]);
				dwvp_pkg::CFG_WAVE_B:       wave_b_q <= dwvp_pkg::wave_t'(cfg_data[1:0]);
				dwvp_pkg::CFG_OUTPUT_MODE:  mode_q <= dwvp_pkg::out_mode_t'(cfg_data[1:0]);
				dwvp_pkg::CFG_NOTE_SAMPLES: note_q <= cfg_data[dwvp_pkg::NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Waveform tables, built at elaboration
	logic signed [SW-1:0] sine_rom [TABLE_SIZE];
	logic signed [SW-1:0] tri_rom  [TABLE_SIZE];

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		localparam logic signed [SW-1:0] SINE_V = dwvp_pkg::sine_entry(g, TABLE_SIZE);
		localparam logic signed [SW-1:0] TRI_V  = dwvp_pkg::tri_entry(g, TABLE_SIZE);
		assign sine_rom[g] = SINE_V;
		assign tri_rom[g]  = TRI_V;
	end

	// Voice state
	logic [PHASE_BITS-1:0]       phase_a_q, phase_b_q;
	logic [dwvp_pkg::NOTE_W-1:0] tick_q;
	logic                        out_valid_q;
	dwvp_pkg::sample_t           out_q;

	// Handshake
	logic tick_xfer;
	assign tick.ready = !out_valid_q || sample.ready;
	assign tick_xfer  = tick.valid && tick.ready;

	// Start clears phases and counter ahead of this tick
	logic [PHASE_BITS-1:0]       phase_a_base, phase_b_base, phase_a_nxt, phase_b_nxt;
	logic [dwvp_pkg::NOTE_W-1:0] tick_base;
	logic                        sounding;

	always_comb begin
		phase_a_base = tick.payload.start_note ? '0 : phase_a_q;
		phase_b_base = tick.payload.start_note ? '0 : phase_b_q;
		tick_base    = tick.payload.start_note ? '0 : tick_q;
		sounding     = (tick_base < note_q);
		phase_a_nxt  = phase_a_base + PHASE_BITS'(incr_a_q);
		phase_b_nxt  = phase_b_base + PHASE_BITS'(incr_b_q);
	end

	// Table lookup per voice
	logic [PROD_W-1:0]    prod_a, prod_b;
	logic [IDX_BITS-1:0]  idx_a, idx_b;
	logic signed [SW-1:0] smp_a, smp_b;

	assign prod_a = PROD_W'(phase_a_nxt) * TABLE_MUL;
	assign prod_b = PROD_W'(phase_b_nxt) * TABLE_MUL;
	assign idx_a  = prod_a[PROD_W-1 -: IDX_BITS];
	assign idx_b  = prod_b[PROD_W-1 -: IDX_BITS];

	always_comb begin
		unique case (wave_a_q)
			dwvp_pkg::WAVE_SINE:   smp_a = sine_rom[idx_a];
			dwvp_pkg::WAVE_SQUARE: smp_a = (idx_a < IDX_HALF) ? dwvp_pkg::PEAK : -dwvp_pkg::PEAK;
			dwvp_pkg::WAVE_TRI:    smp_a = tri_rom[idx_a];
			default:               smp_a = '0;
		endcase
		unique case (wave_b_q)
			dwvp_pkg::WAVE_SINE:   smp_b = sine_rom[idx_b];
			dwvp_pkg::WAVE_SQUARE: smp_b = (idx_b < IDX_HALF) ? dwvp_pkg::PEAK : -dwvp_pkg::PEAK;
			dwvp_pkg::WAVE_TRI:    smp_b = tri_rom[idx_b];
			default:               smp_b = '0;
		endcase
	end

	// Average of both voices, truncated toward zero
	logic signed [SW:0]   sum_ab, avg_ab;
	assign sum_ab = {smp_a[SW-1], smp_a} + {smp_b[SW-1], smp_b};
	assign avg_ab = (sum_ab + {{SW{1'b0}}, sum_ab[SW]}) >>> 1;

	// Output word assembly
	dwvp_pkg::sample_t res;

	always_comb begin
		res.note_done = !sounding;
		if (!sounding) begin
			res.word_a  = dwvp_pkg::CHAN_A_BITS | {4'd0, dwvp_pkg::MIDSCALE};
			res.word_b  = dwvp_pkg::CHAN_B_BITS | {4'd0, dwvp_pkg::MIDSCALE};
			res.b_valid = 1'b1;
		end else begin
			res.word_a  = dwvp_pkg::CHAN_A_BITS | {4'd0, dwvp_pkg::dac_code(smp_a)};
			res.word_b  = dwvp_pkg::CHAN_B_BITS | {4'd0, dwvp_pkg::dac_code(smp_b)};
			res.b_valid = 1'b1;
			if (mode_q == dwvp_pkg::MODE_MONO)
				res.word_b = dwvp_pkg::CHAN_B_BITS | {4'd0, dwvp_pkg::dac_code(smp_a)};
		end
		if (mode_q == dwvp_pkg::MODE_MIX) begin
			res.b_valid = 1'b0;
			res.word_b  = '0;
			if (sounding)
				res.word_a = dwvp_pkg::CHAN_A_BITS |
					{4'd0, dwvp_pkg::dac_code(avg_ab[SW-1:0])};
		end
	end

	// Phase accumulators and sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_a_q <= '0;
			phase_b_q <= '0;
			tick_q    <= '0;
		end else if (tick_xfer) begin
			if (sounding) begin
				phase_a_q <= phase_a_nxt;
				phase_b_q <= phase_b_nxt;
				tick_q    <= tick_base + dwvp_pkg::NOTE_W'(1);
			end else begin
				phase_a_q <= phase_a_base;
				phase_b_q <= phase_b_base;
				tick_q    <= tick_base;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (tick_xfer)
			out_valid_q <= 1'b1;
		else if (sample.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (tick_xfer)
			out_q <= res;
	end

	assign sample.valid   = out_valid_q;
	assign sample.payload = out_q;

`ifndef SYNTHESIS
	// A silence result always carries the midscale word on channel A
	a_silence_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.note_done |->
			out_q.word_a == (dwvp_pkg::CHAN_A_BITS | {4'd0, dwvp_pkg::MIDSCALE}))
		else $error("silence result without midscale word on channel A");

	// Channel B word is zero whenever it is not to be sent
	a_b_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.b_valid |-> out_q.word_b == '0)
		else $error("channel B word nonzero while b_valid is low");

	// A start restarts the counter at zero or one
	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer && tick.payload.start_note |=> tick_q <= dwvp_pkg::NOTE_W'(1))
		else $error("sample counter not restarted by start");

	// Phases hold once the note is over
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer && !tick.payload.start_note && (tick_q >= note_q) |=>
			$stable(phase_a_q) && $stable(phase_b_q) && $stable(tick_q))
		else $error("voice state moved after note end");
`endif

endmodule

`default_nettype wire
